// ----- hdl/sgbt_pkg.sv -----
// ----------------------------------------------------------------------------
// Spatial grid bucket table package
// Shared types, field widths and codes for the grid hash table modules.
// ----------------------------------------------------------------------------
package sgbt_pkg;

  // Field widths
  localparam int CELL_W      = 15;
  localparam int BOXES_W     = 13;
  localparam int CAP_W       = 11;
  localparam int NODE_W      = 15;
  localparam int POS_W       = 16;
  localparam int OP_W        = 2;
  localparam int BUCKET_W    = 16;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 15;
  localparam int DIV_STEPS   = 16;
  localparam int QUEUE_DEPTH = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_FIRST = 2'd2;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOXES_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOXES_Z  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKETS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd6;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_x;
    logic [CELL_W-1:0]  cell_y;
    logic [CELL_W-1:0]  cell_z;
    logic [BOXES_W-1:0] boxes_y;
    logic [BOXES_W-1:0] boxes_z;
    logic [BOXES_W-1:0] bucket_count;
    logic [CAP_W-1:0]   capacity;
  } cfg_t;

  // Classified command handed from the front end to the table engine
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [NODE_W-1:0]   node_id;
    logic [BUCKET_W-1:0] bucket;
    logic                bvalid;
  } cmd_t;

endpackage

// ----- hdl/spatial_grid_bucket_table.sv -----
// ----------------------------------------------------------------------------
// Spatial grid bucket table
// Uniform 3-D grid hash keeping node indices in linked bucket lists.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_tvalid/in_tready/in_tdata; each yields exactly
//   one result word on out_tvalid/out_tready/out_tdata (success, found node).
//   Registers are written on cfg_wr_en with cfg_index and cfg_wdata; the user
//   must write them only while the block is idle, which the block does not enforce.
//   Add and first pass through three 16-step dividers in the front end, two
//   multiply steps and a sum, then the bucket head memory read in the table
//   engine and, for first, the dependent slot memory read. Next goes straight to the slot memory read.
//   Clear sweeps every entry of the bucket head memory.
//   After reset the same clearing pass runs; words are queued meanwhile but
//   not carried out until it ends.
//   A two-word queue separates the front end from the table engine, and the
//   result sits in an output register, so the front end keeps accepting
//   words while the receiver stalls, until the queue fills.
// ----------------------------------------------------------------------------
module spatial_grid_bucket_table #(
  parameter int MAX_BUCKETS = 4096,
  parameter int MAX_SLOTS   = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // opcode[1:0], node_id[16:2], pos_x[32:17], pos_y[48:33], pos_z[64:49]
  input  logic [sgbt_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // success[0], found_node[15:1]
  output logic [sgbt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [sgbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgbt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  sgbt_pkg::cfg_t cfg_r;
  sgbt_pkg::cmd_t q_in, q_out;
  logic           q_push, q_ready, q_valid, q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_x       <= 15'd1;
      cfg_r.cell_y       <= 15'd1;
      cfg_r.cell_z       <= 15'd1;
      cfg_r.boxes_y      <= 13'd1;
      cfg_r.boxes_z      <= 13'd1;
      cfg_r.bucket_count <= 13'd1;
      cfg_r.capacity     <= 11'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sgbt_pkg::REG_CELL_X:   cfg_r.cell_x       <= cfg_wdata;
        sgbt_pkg::REG_CELL_Y:   cfg_r.cell_y       <= cfg_wdata;
        sgbt_pkg::REG_CELL_Z:   cfg_r.cell_z       <= cfg_wdata;
        sgbt_pkg::REG_BOXES_Y:  cfg_r.boxes_y      <= cfg_wdata[12:0];
        sgbt_pkg::REG_BOXES_Z:  cfg_r.boxes_z      <= cfg_wdata[12:0];
        sgbt_pkg::REG_BUCKETS:  cfg_r.bucket_count <= cfg_wdata[12:0];
        sgbt_pkg::REG_CAPACITY: cfg_r.capacity     <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  sgbt_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_push    (q_push),
    .q_ready   (q_ready),
    .q_data    (q_in)
  );

  sgbt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .ready     (q_ready),
    .valid     (q_valid),
    .data      (q_out),
    .pop       (q_pop)
  );

  sgbt_back #(.MAX_BUCKETS(MAX_BUCKETS), .MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .capacity   (cfg_r.capacity),
    .q_valid    (q_valid),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef ASSERT_OFF
  // A command offered to a full queue stays offered and unchanged.
  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_ready) |=> (q_push && $stable(q_in)))
    else $error("command dropped or changed while the queue was full");

  // The engine only takes a command that is present.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("command taken from an empty queue");

  // A failed operation never reports a node.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[15:1] == '0))
    else $error("node reported on a failed operation");
`endif

endmodule

// ----- hdl/sgbt_front.sv -----
// ----------------------------------------------------------------------------
// Grid hash front end
// Accepts input words, divides the position by the cell sizes and forms the
// bucket number for add and first, then hands a classified command to the queue.
// ----------------------------------------------------------------------------
module sgbt_front #(
  parameter int MAX_BUCKETS = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sgbt_pkg::cfg_t                     cfg,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sgbt_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               q_push,
  input  logic                               q_ready,
  output sgbt_pkg::cmd_t                     q_data
);

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_DIV  = 6'b000010,
    F_MULX = 6'b000100,
    F_MULY = 6'b001000,
    F_SUM  = 6'b010000,
    F_PUSH = 6'b100000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [3:0]                   cnt_r;
  logic [sgbt_pkg::POS_W-1:0]   dvd_r [3];
  logic [sgbt_pkg::CELL_W-1:0]  rem_r [3];
  logic                         neg_r [3];
  logic [sgbt_pkg::CELL_W-1:0]  dsr   [3];
  logic [sgbt_pkg::POS_W-1:0]   pos   [3];
  logic [sgbt_pkg::POS_W-1:0]   quo   [3];
  logic [15:0]                  pyz_r, mx_r, my_r;
  sgbt_pkg::cmd_t               cmd_r;
  logic                         accept;
  logic [15:0]                  hsum;
  logic                         hvalid;

  assign in_tready = (state_r == F_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign q_push    = (state_r == F_PUSH);
  assign q_data    = cmd_r;

  assign dsr[0] = cfg.cell_x;
  assign dsr[1] = cfg.cell_y;
  assign dsr[2] = cfg.cell_z;
  assign pos[0] = in_tdata[32:17];
  assign pos[1] = in_tdata[48:33];
  assign pos[2] = in_tdata[64:49];

  // Signed quotients truncated toward zero, kept modulo 2^16
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo[i] = neg_r[i] ? 16'(-dvd_r[i]) : dvd_r[i];
    end
  end

  // Hash sum and its range check
  assign hsum   = mx_r + my_r + quo[2];
  assign hvalid = !hsum[15] && (hsum < 16'(cfg.bucket_count)) &&
                  (17'(hsum) < 17'(MAX_BUCKETS)) &&
                  (cfg.cell_x != '0) && (cfg.cell_y != '0) && (cfg.cell_z != '0);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_tdata[1:0] == sgbt_pkg::OP_ADD || in_tdata[1:0] == sgbt_pkg::OP_FIRST) begin
            state_nxt = F_DIV;
          end else begin
            state_nxt = F_PUSH;
          end
        end
      end
      F_DIV: begin
        if (cnt_r == 4'(sgbt_pkg::DIV_STEPS - 1)) state_nxt = F_MULX;
      end
      F_MULX: state_nxt = F_MULY;
      F_MULY: state_nxt = F_SUM;
      F_SUM:  state_nxt = F_PUSH;
      F_PUSH: begin
        if (q_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: three restoring dividers, one quotient bit a cycle each
  always_ff @(posedge clk) begin
    logic [15:0] trial;
    logic        ge;
    if (accept) begin
      cnt_r          <= '0;
      cmd_r.op       <= in_tdata[1:0];
      cmd_r.node_id  <= in_tdata[16:2];
      cmd_r.bucket   <= '0;
      cmd_r.bvalid   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= pos[i][15];
        dvd_r[i] <= pos[i][15] ? 16'(-pos[i]) : pos[i];
        rem_r[i] <= '0;
      end
    end
    if (state_r == F_DIV) begin
      cnt_r <= cnt_r + 4'd1;
      pyz_r <= 16'(cfg.boxes_y) * 16'(cfg.boxes_z);
      for (int i = 0; i < 3; i++) begin
        trial    = {rem_r[i], dvd_r[i][15]};
        ge       = (trial >= {1'b0, dsr[i]});
        rem_r[i] <= ge ? 15'(trial - {1'b0, dsr[i]}) : trial[14:0];
        dvd_r[i] <= {dvd_r[i][14:0], ge};
      end
    end
    if (state_r == F_MULX) mx_r <= 16'(quo[0] * pyz_r);
    if (state_r == F_MULY) my_r <= 16'(quo[1] * 16'(cfg.boxes_z));
    if (state_r == F_SUM) begin
      cmd_r.bucket <= hsum;
      cmd_r.bvalid <= hvalid;
    end
  end

endmodule

// ----- hdl/sgbt_queue.sv -----
// ----------------------------------------------------------------------------
// Command queue
// A short first-in first-out queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module sgbt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sgbt_pkg::cmd_t push_data,
  output logic           ready,
  output logic           valid,
  output sgbt_pkg::cmd_t data,
  input  logic           pop
);

  sgbt_pkg::cmd_t mem_r [sgbt_pkg::QUEUE_DEPTH];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;

  assign ready = (cnt_r != 2'(sgbt_pkg::QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign data  = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push && ready) wr_ptr_r <= !wr_ptr_r;
      if (pop && valid)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push && ready) - 2'(pop && valid);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push && ready) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- hdl/sgbt_back.sv -----
// ----------------------------------------------------------------------------
// Table engine
// Carries out clear, add, first and next on the bucket head and slot memories
// and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module sgbt_back #(
  parameter int MAX_BUCKETS = 4096,
  parameter int MAX_SLOTS   = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [sgbt_pkg::CAP_W-1:0]         capacity,
  input  logic                               q_valid,
  input  sgbt_pkg::cmd_t                     q_data,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sgbt_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NW = $clog2(MAX_SLOTS + 1);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_CLEAR = 5'b00010,
    B_HEAD  = 5'b00100,
    B_SLOT  = 5'b01000,
    B_OUT   = 5'b10000
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [SW:0]                 head_mem [MAX_BUCKETS];
  logic [sgbt_pkg::NODE_W-1:0] node_mem [MAX_SLOTS];
  logic [SW:0]                 link_mem [MAX_SLOTS];

  sgbt_pkg::cmd_t              cmd_r;
  logic [NW-1:0]               nfs_r;
  logic [SW:0]                 cur_r;
  logic [BW-1:0]               clr_r;
  logic                        clr_rep_r;
  logic                        res_ok_r;
  logic [sgbt_pkg::NODE_W-1:0] res_node_r;
  logic                        out_valid_r;
  logic                        out_ok_r;
  logic [sgbt_pkg::NODE_W-1:0] out_node_r;
  logic [SW:0]                 head_q_r;
  logic [sgbt_pkg::NODE_W-1:0] node_q_r;
  logic [SW:0]                 link_q_r;

  logic                        add_ok, out_free, clr_last;
  logic                        hw_en, sw_en;
  logic [BW-1:0]               hw_addr;
  logic [SW:0]                 hw_data;
  logic [SW-1:0]               sr_addr;

  assign q_pop      = (state_r == B_IDLE) && q_valid;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_node_r, out_ok_r};
  assign clr_last   = (clr_r == BW'(MAX_BUCKETS - 1));
  assign add_ok     = (32'(nfs_r) < 32'(capacity)) && (32'(nfs_r) < 32'(MAX_SLOTS)) &&
                      q_data.bvalid;

  // Memory port selection
  assign hw_en   = (state_r == B_CLEAR) ||
                   (state_r == B_HEAD && cmd_r.op == sgbt_pkg::OP_ADD);
  assign hw_addr = (state_r == B_CLEAR) ? clr_r : cmd_r.bucket[BW-1:0];
  assign hw_data = (state_r == B_CLEAR) ? '0 : {1'b1, nfs_r[SW-1:0]};
  assign sw_en   = (state_r == B_HEAD) && (cmd_r.op == sgbt_pkg::OP_ADD);
  assign sr_addr = (state_r == B_HEAD) ? head_q_r[SW-1:0] : cur_r[SW-1:0];

  always_ff @(posedge clk) begin
    if (hw_en) head_mem[hw_addr] <= hw_data;
    head_q_r <= head_mem[q_data.bucket[BW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      node_mem[nfs_r[SW-1:0]] <= cmd_r.node_id;
      link_mem[nfs_r[SW-1:0]] <= head_q_r;
    end
    node_q_r <= node_mem[sr_addr];
    link_q_r <= link_mem[sr_addr];
  end

  // Operation sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          case (q_data.op)
            sgbt_pkg::OP_CLEAR: state_nxt = B_CLEAR;
            sgbt_pkg::OP_ADD:   state_nxt = add_ok ? B_HEAD : B_OUT;
            sgbt_pkg::OP_FIRST: state_nxt = q_data.bvalid ? B_HEAD : B_OUT;
            default:            state_nxt = cur_r[SW] ? B_SLOT : B_OUT;
          endcase
        end
      end
      B_CLEAR: begin
        if (clr_last) state_nxt = clr_rep_r ? B_OUT : B_IDLE;
      end
      B_HEAD: begin
        if (cmd_r.op == sgbt_pkg::OP_FIRST && head_q_r[SW]) begin
          state_nxt = B_SLOT;
        end else begin
          state_nxt = B_OUT;
        end
      end
      B_SLOT: state_nxt = B_OUT;
      B_OUT: begin
        if (out_free) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control state: the reset runs a clearing pass over the bucket heads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      clr_rep_r   <= 1'b0;
      nfs_r       <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) clr_r <= clr_r + BW'(1);
      if (q_pop) begin
        case (q_data.op)
          sgbt_pkg::OP_CLEAR: begin
            clr_r     <= '0;
            clr_rep_r <= 1'b1;
            nfs_r     <= '0;
            cur_r     <= '0;
          end
          sgbt_pkg::OP_FIRST: begin
            if (!q_data.bvalid) cur_r <= '0;
          end
          default: ;
        endcase
      end
      if (state_r == B_HEAD) begin
        if (cmd_r.op == sgbt_pkg::OP_ADD) begin
          nfs_r <= nfs_r + NW'(1);
        end else begin
          cur_r <= head_q_r;
        end
      end
      if (state_r == B_SLOT) cur_r <= link_q_r;
      // The result register loads when free, otherwise empties when taken.
      if (state_r == B_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r      <= q_data;
      res_ok_r   <= 1'b0;
      res_node_r <= '0;
    end
    if (state_r == B_CLEAR) res_ok_r <= 1'b1;
    if (state_r == B_HEAD && cmd_r.op == sgbt_pkg::OP_ADD) res_ok_r <= 1'b1;
    if (state_r == B_SLOT) begin
      res_ok_r   <= 1'b1;
      res_node_r <= node_q_r;
    end
    if (state_r == B_OUT && out_free) begin
      out_ok_r   <= res_ok_r;
      out_node_r <= res_node_r;
    end
  end

endmodule

// ----- dv/tb_spatial_grid_bucket_table.sv -----
// ----------------------------------------------------------------------------
// Spatial grid bucket table testbench
// Drives clear, add, first and next words through the stream ports under
// several register settings and idling phases, predicts each result word
// from a model of the grid hash kept here, and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_spatial_grid_bucket_table;

  localparam int NB = 4096;
  localparam int NS = 1024;
  localparam int STALL_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [sgbt_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [sgbt_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [sgbt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sgbt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  spatial_grid_bucket_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [sgbt_pkg::OP_W-1:0] op;
    logic [sgbt_pkg::NODE_W-1:0] node;
    logic signed [sgbt_pkg::POS_W-1:0] x, y, z;
  } word_t;

  typedef struct packed {
    logic ok;
    logic [sgbt_pkg::NODE_W-1:0] node;
  } res_t;

  // Grid state as the block should hold it.
  sgbt_pkg::cfg_t grid_cfg;
  logic [sgbt_pkg::CAP_W-1:0] head_slot [NB];
  logic head_ok [NB];
  logic [sgbt_pkg::NODE_W-1:0] slot_node [NS];
  logic [sgbt_pkg::CAP_W-1:0] slot_link [NS];
  logic link_ok [NS];
  int unsigned free_slot;
  logic [sgbt_pkg::CAP_W-1:0] cursor;
  logic cursor_ok;

  res_t expected_words[$];
  int errors = 0;
  int idle_pct_in = 0, idle_pct_out = 0;
  int hold_cycles = 0;
  int quiet = 0;

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic void empty_grid();
    for (int i = 0; i < NB; i++) head_ok[i] = 1'b0;
    free_slot = 0;
    cursor_ok = 1'b0;
  endfunction

  // Truncating division per axis, then the 16-bit signed reduction of the sum.
  function automatic bit locate_bucket(input word_t w, output int unsigned b);
    longint qx, qy, qz, sum;
    int unsigned h;
    if (grid_cfg.cell_x == 0 || grid_cfg.cell_y == 0 || grid_cfg.cell_z == 0) return 0;
    qx = longint'(w.x) / longint'(grid_cfg.cell_x);
    qy = longint'(w.y) / longint'(grid_cfg.cell_y);
    qz = longint'(w.z) / longint'(grid_cfg.cell_z);
    sum = qx * (longint'(grid_cfg.boxes_y) * longint'(grid_cfg.boxes_z))
        + qy * longint'(grid_cfg.boxes_z) + qz;
    h = 32'(sum[15:0]);
    if (h >= 32'h8000 || h >= grid_cfg.bucket_count || h >= NB) return 0;
    b = h;
    return 1;
  endfunction

  function automatic res_t grid_step(input word_t w);
    res_t r;
    int unsigned b;
    r = '0;
    case (w.op)
      sgbt_pkg::OP_CLEAR: begin
        empty_grid();
        r.ok = 1'b1;
      end
      sgbt_pkg::OP_ADD: begin
        if (free_slot < grid_cfg.capacity && free_slot < NS && locate_bucket(w, b)) begin
          slot_node[free_slot] = w.node;
          slot_link[free_slot] = head_slot[b];
          link_ok[free_slot] = head_ok[b];
          head_slot[b] = sgbt_pkg::CAP_W'(free_slot);
          head_ok[b] = 1'b1;
          free_slot++;
          r.ok = 1'b1;
        end
      end
      default: begin
        if (w.op == sgbt_pkg::OP_FIRST) begin
          if (locate_bucket(w, b)) begin
            cursor = head_slot[b];
            cursor_ok = head_ok[b];
          end else cursor_ok = 1'b0;
        end
        if (cursor_ok && cursor < NS) begin
          r.node = slot_node[cursor];
          r.ok = 1'b1;
          cursor_ok = link_ok[cursor];
          cursor = slot_link[cursor];
        end else cursor_ok = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [sgbt_pkg::IN_TDATA_W-1:0] pack_word(input word_t w);
    logic [sgbt_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    d[1:0] = w.op;
    d[16:2] = w.node;
    d[32:17] = w.x;
    d[48:33] = w.y;
    d[64:49] = w.z;
    return d;
  endfunction

  task automatic write_reg(input logic [sgbt_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[sgbt_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      sgbt_pkg::REG_CELL_X:   grid_cfg.cell_x = sgbt_pkg::CELL_W'(val);
      sgbt_pkg::REG_CELL_Y:   grid_cfg.cell_y = sgbt_pkg::CELL_W'(val);
      sgbt_pkg::REG_CELL_Z:   grid_cfg.cell_z = sgbt_pkg::CELL_W'(val);
      sgbt_pkg::REG_BOXES_Y:  grid_cfg.boxes_y = sgbt_pkg::BOXES_W'(val);
      sgbt_pkg::REG_BOXES_Z:  grid_cfg.boxes_z = sgbt_pkg::BOXES_W'(val);
      sgbt_pkg::REG_BUCKETS:  grid_cfg.bucket_count = sgbt_pkg::BOXES_W'(val);
      sgbt_pkg::REG_CAPACITY: grid_cfg.capacity = sgbt_pkg::CAP_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_grid(input int cx, cy, cz, by, bz, bc, cap);
    write_reg(sgbt_pkg::REG_CELL_X, cx);
    write_reg(sgbt_pkg::REG_CELL_Y, cy);
    write_reg(sgbt_pkg::REG_CELL_Z, cz);
    write_reg(sgbt_pkg::REG_BOXES_Y, by);
    write_reg(sgbt_pkg::REG_BOXES_Z, bz);
    write_reg(sgbt_pkg::REG_BUCKETS, bc);
    write_reg(sgbt_pkg::REG_CAPACITY, cap);
  endtask

  // Offer one word, holding valid until it is taken. The expectation is
  // queued at acceptance; a typed-in result replaces the predicted one.
  task automatic offer_word(input word_t w, input bit fixed, input res_t fixed_res);
    res_t pred;
    while (($urandom_range(99) < idle_pct_in)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pack_word(w);
    do @(posedge clk); while (!in_tready);
    pred = grid_step(w);
    if (fixed && pred !== fixed_res) report("table row disagrees with the predictor");
    expected_words.push_back(fixed ? fixed_res : pred);
  endtask

  task automatic send_word(input word_t w);
    offer_word(w, 1'b0, '0);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic word_t random_word(input int span);
    word_t w;
    int r;
    r = $urandom_range(99);
    w.op = (r < 3) ? sgbt_pkg::OP_CLEAR : (r < 45) ? sgbt_pkg::OP_ADD :
           (r < 70) ? sgbt_pkg::OP_FIRST : sgbt_pkg::OP_NEXT;
    w.node = sgbt_pkg::NODE_W'($urandom);
    if (span == 0) begin
      w.x = 16'($urandom); w.y = 16'($urandom); w.z = 16'($urandom);
    end else begin
      w.x = 16'($urandom_range(span) - span / 4);
      w.y = 16'($urandom_range(span) - span / 4);
      w.z = 16'($urandom_range(span) - span / 4);
    end
    return w;
  endfunction

  // Receiver readiness and the long hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else out_tready <= ($urandom_range(99) >= idle_pct_out);
  end

  // Result word checking.
  always @(posedge clk) begin
    res_t got, want;
    if (out_tvalid && out_tready) begin
      got.ok = out_tdata[0];
      got.node = out_tdata[15:1];
      if (expected_words.size() == 0) report("result word with nothing expected");
      else begin
        want = expected_words.pop_front();
        if (got.ok !== want.ok)
          report($sformatf("success %b, expected %b", got.ok, want.ok));
        if (got.node !== want.node)
          report($sformatf("found_node %0d, expected %0d", got.node, want.node));
      end
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > STALL_LIMIT) begin
      $display("tb_spatial_grid_bucket_table: done, errors");
      $finish;
    end
  end

  word_t directed [];
  bit want_known [];
  res_t want_val [];

  initial begin
    word_t w;
    int phase;
    grid_cfg = '{cell_x: 1, cell_y: 1, cell_z: 1, boxes_y: 1, boxes_z: 1,
                 bucket_count: 1, capacity: 0};
    for (int i = 0; i < NS; i++) begin
      slot_node[i] = '0; slot_link[i] = '0; link_ok[i] = 1'b0;
    end
    empty_grid();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: capacity 0, so adds fail; lookups find nothing.
    directed = '{
      '{sgbt_pkg::OP_ADD, 15'h7fff, 16'sd0, 16'sd0, 16'sd0},
      '{sgbt_pkg::OP_FIRST, 15'd0, 16'sd0, 16'sd0, 16'sd0},
      '{sgbt_pkg::OP_NEXT, 15'd0, 16'sd0, 16'sd0, 16'sd0},
      '{sgbt_pkg::OP_CLEAR, 15'd0, 16'sd0, 16'sd0, 16'sd0}
    };
    want_known = '{1, 1, 1, 1};
    want_val = '{'{1'b0, 15'd0}, '{1'b0, 15'd0}, '{1'b0, 15'd0}, '{1'b1, 15'd0}};
    foreach (directed[i]) offer_word(directed[i], want_known[i], want_val[i]);
    drain();

    // Small grid: lists, extremes, invalid positions and overflow.
    set_grid(4, 4, 4, 8, 8, 512, 1024);
    directed = '{
      '{sgbt_pkg::OP_ADD, 15'd0, 16'sd0, 16'sd0, 16'sd0},
      '{sgbt_pkg::OP_ADD, 15'h7fff, 16'sd1, 16'sd2, 16'sd3},
      '{sgbt_pkg::OP_ADD, 15'h5555, 16'sd3, 16'sd3, 16'sd3},
      '{sgbt_pkg::OP_FIRST, 15'd0, 16'sd2, 16'sd2, 16'sd2},
      '{sgbt_pkg::OP_NEXT, 15'd0, 16'sd0, 16'sd0, 16'sd0},
      '{sgbt_pkg::OP_NEXT, 15'd0, 16'sd0, 16'sd0, 16'sd0},
      '{sgbt_pkg::OP_NEXT, 15'd0, 16'sd0, 16'sd0, 16'sd0},
      '{sgbt_pkg::OP_NEXT, 15'd0, 16'sd0, 16'sd0, 16'sd0},
      '{sgbt_pkg::OP_ADD, 15'd9, -16'sd5, 16'sd0, 16'sd0},
      '{sgbt_pkg::OP_ADD, 15'd9, -16'sd3, -16'sd3, -16'sd3},
      '{sgbt_pkg::OP_ADD, 15'd8, 16'sh7fff, 16'sh7fff, 16'sh7fff},
      '{sgbt_pkg::OP_ADD, 15'd7, -16'sh8000, -16'sh8000, -16'sh8000},
      '{sgbt_pkg::OP_FIRST, 15'd0, -16'sh8000, 16'sd0, 16'sd0},
      '{sgbt_pkg::OP_FIRST, 15'd0, 16'sd0, 16'sd0, 16'sd0},
      '{sgbt_pkg::OP_ADD, 15'd6, 16'sd40, 16'sd40, 16'sd40},
      '{sgbt_pkg::OP_FIRST, 15'd0, 16'sd40, 16'sd41, 16'sd42},
      '{sgbt_pkg::OP_CLEAR, 15'd0, 16'sd0, 16'sd0, 16'sd0},
      '{sgbt_pkg::OP_FIRST, 15'd0, 16'sd0, 16'sd0, 16'sd0}
    };
    foreach (directed[i]) send_word(directed[i]);
    drain();

    // Full table: capacity 2 and a zero cell size.
    set_grid(1, 1, 1, 1, 1, 1, 2);
    for (int i = 0; i < 3; i++)
      send_word('{sgbt_pkg::OP_ADD, 15'(i + 1), 16'sd0, 16'sd0, 16'sd0});
    send_word('{sgbt_pkg::OP_FIRST, 15'd0, 16'sd0, 16'sd0, 16'sd0});
    drain();
    write_reg(sgbt_pkg::REG_CELL_Y, 0);
    send_word('{sgbt_pkg::OP_FIRST, 15'd0, 16'sd0, 16'sd0, 16'sd0});
    send_word('{sgbt_pkg::OP_CLEAR, 15'd0, 16'sd0, 16'sd0, 16'sd0});
    drain();

    // Random phases over several settings and idling mixes.
    for (phase = 0; phase < 6; phase++) begin
      int span;
      case (phase)
        0: begin set_grid(8, 8, 8, 16, 16, 4096, 1024); span = 200;
                 idle_pct_in = 0; idle_pct_out = 0; end
        1: begin set_grid(32767, 32767, 32767, 4096, 4096, 4096, 1024); span = 0;
                 idle_pct_in = 52; idle_pct_out = 0; end
        2: begin set_grid(1, 1, 1, 1, 1, 1, 1); span = 3;
                 idle_pct_in = 0; idle_pct_out = 52; end
        3: begin set_grid(3, 5, 7, 13, 9, 1000, 300); span = 120;
                 idle_pct_in = 21; idle_pct_out = 21; end
        4: begin set_grid(1, 1, 1, 4096, 4096, 4096, 1024); span = 0;
                 idle_pct_in = 0; idle_pct_out = 0; end
        default: begin set_grid(16, 2, 100, 40, 7, 4096, 700); span = 600;
                 idle_pct_in = 52; idle_pct_out = 52; end
      endcase
      for (int n = 0; n < 300; n++) begin
        w = random_word(span);
        // Clears are slow; keep them rare.
        if (w.op == sgbt_pkg::OP_CLEAR && $urandom_range(3) != 0) w.op = sgbt_pkg::OP_FIRST;
        if (phase == 0 && n == 100) hold_cycles = 400;
        send_word(w);
      end
      drain();
    end

    if (errors == 0) $display("tb_spatial_grid_bucket_table: done, clean");
    else $display("tb_spatial_grid_bucket_table: done, errors");
    $finish;
  end

endmodule
